// ===== rtl/consistent_hash_ring_macros.svh =====
// assertion macros used by the checker file
`ifndef CONSISTENT_HASH_RING_MACROS_SVH
`define CONSISTENT_HASH_RING_MACROS_SVH

// same-cycle implication
`define CHR_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("consistent_hash_ring assertion failed");

// next-cycle implication
`define CHR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("consistent_hash_ring assertion failed");

`endif

// ===== rtl/chr_pkg.sv =====
// types and constants shared by the hash ring modules
package chr_pkg;
   localparam int RING_POINTS     = 1024;
   localparam int PT_W            = 10;
   localparam int CNT_W           = 11;
   localparam int MAX_MACHINES    = 256;
   localparam int ID_W            = 8;
   localparam int MAX_POINTS_EACH = 16;
   localparam int K_W             = 5;
   localparam int LFSR_W          = 16;
   localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;
   localparam int CSR_IDX_W       = 2;
   localparam int CSR_DATA_W      = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_RING_SIZE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PPM       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SEED      = 2'd2;

   localparam logic KIND_ADD  = 1'b0;
   localparam logic KIND_LOOK = 1'b1;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic            kind;
      logic [ID_W-1:0] node_id;
      logic [PT_W-1:0] hash_code;
   } req_type;

   typedef struct packed {
      logic [PT_W-1:0] point;
      logic [ID_W-1:0] owner_id;
      logic [1:0]      status;
      logic            last;
   } rsp_type;

   typedef struct packed {
      logic            taken;
      logic [ID_W-1:0] owner;
   } entry_type;
endpackage

// ===== rtl/chr_ring_mem.sv =====
// ring point memory, one write and one registered read port
module chr_ring_mem import chr_pkg::*; (
   input  logic            clock,
   input  logic            wr_en,
   input  logic [PT_W-1:0] wr_addr,
   input  entry_type       wr_data,
   input  logic            rd_en,
   input  logic [PT_W-1:0] rd_addr,
   output entry_type       rd_data
);
   entry_type mem [RING_POINTS];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/chr_mod_unit.sv =====
// bit-serial remainder of the lfsr value by the ring size
module chr_mod_unit import chr_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [LFSR_W-1:0] dividend,
   input  logic [CNT_W-1:0]  divisor,
   output logic              done,
   output logic [CNT_W-1:0]  remainder
);
   localparam int STEP_W = $clog2(LFSR_W);

   logic              busy_ff;
   logic              done_ff;
   logic [STEP_W-1:0] step_ff;
   logic [LFSR_W-1:0] dvd_ff;
   logic [CNT_W-1:0]  rem_ff;
   logic [CNT_W:0]    trial;
   logic [CNT_W-1:0]  rem_in;

   always_comb begin
      trial = {rem_ff, dvd_ff[LFSR_W-1]};
      if (trial >= {1'b0, divisor}) begin
         rem_in = CNT_W'(trial - {1'b0, divisor});
      end else begin
         rem_in = trial[CNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
            dvd_ff  <= dividend;
            rem_ff  <= '0;
         end else if (busy_ff) begin
            rem_ff  <= rem_in;
            dvd_ff  <= {dvd_ff[LFSR_W-2:0], 1'b0};
            step_ff <= step_ff + 1'b1;
            if (step_ff == STEP_W'(LFSR_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;
endmodule

// ===== rtl/consistent_hash_ring.sv =====
// consistent hash ring: add machines at pseudo-random points, look up hash owners
// lookup: first taken point from the hash code on, or empty after all 1024; req_stall high until the result
// add: presence read, count of free points in the first ring_size entries, draws until k
//   points are claimed (taken points redrawn), then a sweep of all 1024 entries reports the points in order
// re-add skips count and draws; ring full answers after the count; stalls add
// reset: clearing pass over both memories, req_stall held high
module consistent_hash_ring import chr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_payload,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);
   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_PRES, S_COUNT, S_FULL, S_DRAW, S_DIV, S_CHECK, S_EMIT, S_LOOK,
      S_FINAL
   } state_type;

   state_type         state_ff;
   logic [CNT_W-1:0]  ring_size_ff;
   logic [K_W-1:0]    ppm_ff;
   logic [LFSR_W-1:0] lfsr_ff;
   logic              present_mem [MAX_MACHINES];
   logic              present_rd_ff;
   logic [ID_W-1:0]   id_ff;
   logic [PT_W-1:0]   scan_addr_ff;
   logic [CNT_W-1:0]  scan_cnt_ff;
   logic              rd_vld_ff;
   logic [PT_W-1:0]   rd_pt_ff;
   logic [CNT_W-1:0]  free_ff;
   logic [K_W-1:0]    claimed_ff;
   logic [K_W-1:0]    found_ff;
   logic              pend_vld_ff;
   logic [PT_W-1:0]   pend_pt_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_data_ff;

   logic [CNT_W-1:0]  rs_eff;
   logic [K_W-1:0]    k_eff;
   logic [CNT_W-1:0]  scan_limit;
   logic [LFSR_W-1:0] lfsr_in;
   logic              out_free, hit_emit, hit_look, hold, scanning, issue, scan_done;
   logic              mem_wr_en, mem_rd_en;
   logic [PT_W-1:0]   mem_wr_addr, mem_rd_addr;
   entry_type         mem_wr_data, mem_rd_data;
   logic              pres_wr_en, pres_wr_data;
   logic [ID_W-1:0]   pres_wr_addr;
   logic              div_start, div_done;
   logic [CNT_W-1:0]  div_rem;

   always_comb begin
      if (ring_size_ff == '0) begin
         rs_eff = CNT_W'(1);
      end else if (ring_size_ff > CNT_W'(RING_POINTS)) begin
         rs_eff = CNT_W'(RING_POINTS);
      end else begin
         rs_eff = ring_size_ff;
      end
      if (ppm_ff == '0) begin
         k_eff = K_W'(1);
      end else if (ppm_ff > K_W'(MAX_POINTS_EACH)) begin
         k_eff = K_W'(MAX_POINTS_EACH);
      end else begin
         k_eff = ppm_ff;
      end
      lfsr_in = {1'b0, lfsr_ff[LFSR_W-1:1]} ^ (lfsr_ff[0] ? LFSR_TAPS : '0);
   end

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign hit_emit   = rd_vld_ff && mem_rd_data.taken && (mem_rd_data.owner == id_ff)
                       && (found_ff < K_W'(MAX_POINTS_EACH));
   assign hit_look   = rd_vld_ff && mem_rd_data.taken;
   assign hold       = ((state_ff == S_EMIT) && hit_emit && pend_vld_ff && !out_free)
                    || ((state_ff == S_LOOK) && hit_look && !out_free);
   assign scanning   = (state_ff == S_COUNT) || (state_ff == S_EMIT) || (state_ff == S_LOOK);
   assign scan_limit = (state_ff == S_COUNT) ? rs_eff : CNT_W'(RING_POINTS);
   assign issue      = scanning && !hold && (scan_cnt_ff < scan_limit);
   assign scan_done  = (scan_cnt_ff == scan_limit) && !rd_vld_ff;
   assign div_start  = (state_ff == S_DRAW);

   always_comb begin
      mem_rd_en   = issue || ((state_ff == S_DIV) && div_done);
      mem_rd_addr = (state_ff == S_DIV) ? div_rem[PT_W-1:0] : scan_addr_ff;
      mem_wr_en   = 1'b0;
      mem_wr_addr = scan_addr_ff;
      mem_wr_data = '0;
      if (state_ff == S_CLEAR) begin
         mem_wr_en = 1'b1;
      end else if ((state_ff == S_CHECK) && !mem_rd_data.taken) begin
         mem_wr_en   = 1'b1;
         mem_wr_addr = rd_pt_ff;
         mem_wr_data = '{taken: 1'b1, owner: id_ff};
      end
   end

   always_comb begin
      pres_wr_en   = 1'b0;
      pres_wr_addr = scan_addr_ff[ID_W-1:0];
      pres_wr_data = 1'b0;
      if (state_ff == S_CLEAR) begin
         pres_wr_en = 1'b1;
      end else if ((state_ff == S_CHECK) && !mem_rd_data.taken
                   && (claimed_ff + 1'b1 == k_eff)) begin
         pres_wr_en   = 1'b1;
         pres_wr_addr = id_ff;
         pres_wr_data = 1'b1;
      end
   end

   // presence memory, read at the offered machine id every cycle
   always_ff @(posedge clock) begin
      if (pres_wr_en) begin
         present_mem[pres_wr_addr] <= pres_wr_data;
      end
      present_rd_ff <= present_mem[req_payload.node_id];
   end

   chr_ring_mem u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   chr_mod_unit u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (lfsr_in),
      .divisor   (rs_eff),
      .done      (div_done),
      .remainder (div_rem)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         ring_size_ff <= CNT_W'(RING_POINTS);
         ppm_ff       <= K_W'(3);
         lfsr_ff      <= LFSR_W'(1);
         scan_addr_ff <= '0;
         scan_cnt_ff  <= '0;
         rd_vld_ff    <= 1'b0;
         pend_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_RING_SIZE: ring_size_ff <= csr_wdata[CNT_W-1:0];
               CSR_PPM:       ppm_ff <= csr_wdata[K_W-1:0];
               CSR_SEED:      lfsr_ff <= (csr_wdata == '0) ? LFSR_W'(1) : csr_wdata;
               default: ;
            endcase
         end
         if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         // shared sweep engine, one read issued per cycle unless a result is blocked
         if (scanning && !hold) begin
            rd_vld_ff <= issue;
            if (issue) begin
               rd_pt_ff     <= scan_addr_ff;
               scan_addr_ff <= scan_addr_ff + 1'b1;
               scan_cnt_ff  <= scan_cnt_ff + 1'b1;
            end
         end
         unique case (state_ff)
            S_CLEAR: begin
               scan_addr_ff <= scan_addr_ff + 1'b1;
               if (scan_addr_ff == PT_W'(RING_POINTS - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_valid) begin
                  id_ff       <= req_payload.node_id;
                  scan_cnt_ff <= '0;
                  rd_vld_ff   <= 1'b0;
                  pend_vld_ff <= 1'b0;
                  found_ff    <= '0;
                  free_ff     <= '0;
                  if (req_payload.kind == KIND_LOOK) begin
                     scan_addr_ff <= req_payload.hash_code;
                     state_ff     <= S_LOOK;
                  end else begin
                     scan_addr_ff <= '0;
                     state_ff     <= S_PRES;
                  end
               end
            end
            S_PRES: begin
               state_ff <= present_rd_ff ? S_EMIT : S_COUNT;
            end
            S_COUNT: begin
               if (rd_vld_ff && !mem_rd_data.taken) begin
                  free_ff <= free_ff + 1'b1;
               end
               if (scan_done) begin
                  claimed_ff <= '0;
                  state_ff   <= (free_ff < CNT_W'(k_eff)) ? S_FULL : S_DRAW;
               end
            end
            S_FULL: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= '{point: '0, owner_id: id_ff, status: ST_FULL, last: 1'b1};
                  state_ff     <= S_IDLE;
               end
            end
            S_DRAW: begin
               lfsr_ff  <= lfsr_in;
               state_ff <= S_DIV;
            end
            S_DIV: begin
               if (div_done) begin
                  rd_pt_ff <= div_rem[PT_W-1:0];
                  state_ff <= S_CHECK;
               end
            end
            S_CHECK: begin
               state_ff <= S_DRAW;
               if (!mem_rd_data.taken) begin
                  claimed_ff <= claimed_ff + 1'b1;
                  if (claimed_ff + 1'b1 == k_eff) begin
                     scan_addr_ff <= '0;
                     scan_cnt_ff  <= '0;
                     rd_vld_ff    <= 1'b0;
                     state_ff     <= S_EMIT;
                  end
               end
            end
            S_EMIT: begin
               // hold one point back so the final one can carry last
               if (hit_emit && !hold) begin
                  if (pend_vld_ff) begin
                     rsp_valid_ff <= 1'b1;
                     rsp_data_ff  <= '{point: pend_pt_ff, owner_id: id_ff,
                                       status: ST_OK, last: 1'b0};
                  end
                  pend_pt_ff  <= rd_pt_ff;
                  pend_vld_ff <= 1'b1;
                  found_ff    <= found_ff + 1'b1;
               end
               if (scan_done) begin
                  state_ff <= S_FINAL;
               end
            end
            S_FINAL: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= '{point: pend_vld_ff ? pend_pt_ff : '0, owner_id: id_ff,
                                    status: ST_OK, last: 1'b1};
                  state_ff     <= S_IDLE;
               end
            end
            S_LOOK: begin
               if (hit_look && out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= '{point: rd_pt_ff, owner_id: mem_rd_data.owner,
                                    status: ST_OK, last: 1'b1};
                  rd_vld_ff    <= 1'b0;
                  state_ff     <= S_IDLE;
               end else if (scan_done && out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= '{point: '0, owner_id: '0, status: ST_EMPTY, last: 1'b1};
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_stall   = (state_ff != S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;
endmodule

// ===== rtl/chr_checker.sv =====
// port-level checker for the hash ring, bound to the top level
`include "consistent_hash_ring_macros.svh"
module chr_checker import chr_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_payload
);
   logic rsp_blocked, rsp_err, rsp_empty, empty_zero, req_fire;

   assign rsp_blocked = rsp_valid && rsp_stall;
   assign rsp_err     = rsp_valid && (rsp_payload.status != ST_OK);
   assign rsp_empty   = rsp_valid && (rsp_payload.status == ST_EMPTY);
   assign empty_zero  = (rsp_payload.point == '0) && (rsp_payload.owner_id == '0);
   assign req_fire    = req_valid && !req_stall;

   `CHR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_blocked, rsp_valid && $stable(rsp_payload))
   `CHR_ASSERT_IMPL(a_err_last, clock, reset, rsp_err, rsp_payload.last)
   `CHR_ASSERT_IMPL(a_empty_zero, clock, reset, rsp_empty, empty_zero)
   `CHR_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_fire, req_stall)
   `CHR_ASSERT_IMPL(a_clear_after_reset, clock, reset, $past(reset), req_stall)
endmodule

bind consistent_hash_ring chr_checker u_chr_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);
